FILE: design/command_line_tokenizer_unit_macros.svh
// Assertion macros used by the lexer (clt_lexer) of the command-line tokenizer.
// Every macro samples on clk and is disabled while rst is high.
`ifndef COMMAND_LINE_TOKENIZER_UNIT_MACROS_SVH
`define COMMAND_LINE_TOKENIZER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("command line tokenizer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CLT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("command line tokenizer: next-cycle check failed");

`endif

FILE: design/clt_pkg.sv
// Shared types and constants of the command-line tokenizer.
// No dependencies; clt_lexer, the top level and the testbench import this package.
package clt_pkg;

  // Largest number of arguments counted in one command (legal range 1 to 7).
  localparam int unsigned MaxArgs = 7;
  // The count field is three bits wide, so the usable limit saturates at 7.
  localparam logic [2:0] CountLimit = (MaxArgs < 7) ? 3'(MaxArgs) : 3'd7;

  localparam logic [7:0] ChNul       = 8'h00;
  localparam logic [7:0] ChSemi      = 8'h3B;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChBackslash = 8'h5C;

  typedef enum logic [1:0] {
    BEGIN_NONE   = 2'd0,
    BEGIN_BARE   = 2'd1,
    BEGIN_QUOTED = 2'd2
  } begin_code_t;

  typedef enum logic [1:0] {
    END_NONE = 2'd0,
    END_SEMI = 2'd1,
    END_LINE = 2'd2
  } end_code_t;

  typedef struct packed {
    logic [7:0]  out_char;
    begin_code_t begins_arg;
    end_code_t   ends_command;
    logic [2:0]  arg_count;
    logic        overflow;
  } tok_t;

endpackage

FILE: design/clt_if.sv
// Valid/ready channel interfaces of the command-line tokenizer.
// Depends on nothing but plain logic types.
interface clt_cmd_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;

  modport source (output valid, output in_char, input ready);
  modport sink (input valid, input in_char, output ready);
endinterface

interface clt_tok_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic [1:0] begins_arg;
  logic [1:0] ends_command;
  logic [2:0] arg_count;
  logic       overflow;

  modport source (
    output valid, output out_char, output begins_arg, output ends_command,
    output arg_count, output overflow, input ready
  );
  modport sink (
    input valid, input out_char, input begins_arg, input ends_command,
    input arg_count, input overflow, output ready
  );
endinterface

FILE: design/clt_lexer.sv
// Lexer state and per-byte step logic of the command-line tokenizer.
// Depends on clt_pkg and command_line_tokenizer_unit_macros.svh.
`include "command_line_tokenizer_unit_macros.svh"

module clt_lexer
  import clt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] step_char,
  output tok_t       result
);

  typedef enum logic [1:0] {
    LX_SPACE  = 2'd0,
    LX_TOKEN  = 2'd1,
    LX_QUOTED = 2'd2,
    LX_ESCAPE = 2'd3
  } lex_state_t;

  lex_state_t lex_state, lex_state_next;
  lex_state_t saved_state, saved_state_next;
  logic [2:0] arg_total, arg_total_next;
  logic       too_many, too_many_next;

  logic        arg_start;
  logic        can_count;
  logic [7:0]  ch;
  begin_code_t begins;
  end_code_t   ends;

  always_comb begin
    ch               = step_char;
    begins           = BEGIN_NONE;
    ends             = END_NONE;
    lex_state_next   = lex_state;
    saved_state_next = saved_state;
    arg_start        = 1'b0;
    priority if (step_char == ChNul) begin
      ends = END_LINE;
    end else if (step_char == ChSemi && lex_state != LX_QUOTED &&
                 lex_state != LX_ESCAPE) begin
      ends = END_SEMI;
      ch   = ChNul;
    end else if (lex_state == LX_ESCAPE) begin
      lex_state_next = saved_state;
    end else if (lex_state == LX_QUOTED) begin
      if (step_char == ChQuote) begin
        ch             = ChNul;
        lex_state_next = LX_SPACE;
      end
    end else if (step_char == ChSpace || step_char == ChTab) begin
      ch             = ChNul;
      lex_state_next = LX_SPACE;
    end else if (step_char == ChQuote) begin
      ch             = ChNul;
      begins         = BEGIN_QUOTED;
      arg_start      = 1'b1;
      lex_state_next = LX_QUOTED;
    end else if (step_char == ChBackslash) begin
      saved_state_next = lex_state;
      lex_state_next   = LX_ESCAPE;
    end else begin
      if (lex_state == LX_SPACE) begin
        begins    = BEGIN_BARE;
        arg_start = 1'b1;
      end
      lex_state_next = LX_TOKEN;
    end
  end

  // A start at the limit keeps the count and raises the overflow flag.
  assign can_count      = (arg_total < CountLimit);
  assign arg_total_next = (arg_start && can_count) ? arg_total + 3'd1 : arg_total;
  assign too_many_next  = too_many | (arg_start & ~can_count);

  assign result = '{
    out_char:     ch,
    begins_arg:   begins,
    ends_command: ends,
    arg_count:    arg_total_next,
    overflow:     too_many_next
  };

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_state   <= LX_SPACE;
      saved_state <= LX_SPACE;
      arg_total   <= 3'd0;
      too_many    <= 1'b0;
    end else if (step) begin
      if (ends != END_NONE) begin
        lex_state   <= LX_SPACE;
        saved_state <= LX_SPACE;
        arg_total   <= 3'd0;
        too_many    <= 1'b0;
      end else begin
        lex_state   <= lex_state_next;
        saved_state <= saved_state_next;
        arg_total   <= arg_total_next;
        too_many    <= too_many_next;
      end
    end
  end

  `CLT_ASSERT_SAME(a_count_in_limit, 1'b1, arg_total <= CountLimit)
  `CLT_ASSERT_SAME(a_saved_is_plain, 1'b1, saved_state == LX_SPACE || saved_state == LX_TOKEN)
  `CLT_ASSERT_NEXT(a_end_clears, step && ends != END_NONE,
                   lex_state == LX_SPACE && arg_total == 3'd0 && !too_many)
  `CLT_ASSERT_SAME(a_start_not_end, step && begins != BEGIN_NONE, ends == END_NONE)

endmodule

FILE: design/command_line_tokenizer_unit.sv
// Top level of the command-line tokenizer: input register, lexer, result register.
// Depends on clt_pkg, clt_if (clt_cmd_if, clt_tok_if) and clt_lexer.

// The tokenizer takes one command-line byte per beat on cmd and returns exactly
// one result beat on tok for each: the byte (zeroed where a blank, tab, quote,
// unquoted ';' or NUL becomes a terminator), a mark where an argument begins,
// a mark where the command ends, the running argument count and an overflow
// flag. It sustains one byte per clock cycle while tok is not stalled. A byte
// is taken into the input register, and its result is registered in the
// result register once that stage is free or drains, so a stall on tok can
// hold it back. The single lexer state update lies between the input register
// and the result register. A byte can be taken while a finished result still
// waits on tok, since the input register and the result register are separate
// stages. After a ';' or NUL the lexer starts the next command from blank
// state with a zero count. Counting saturates at the package limit.
module command_line_tokenizer_unit
  import clt_pkg::*;
(
  input logic         clk,
  input logic         rst,
  clt_cmd_if.sink     cmd,
  clt_tok_if.source   tok
);

  // Input register stage.
  logic       byte_valid;
  logic [7:0] byte_q;
  // Result register stage.
  logic       res_valid;
  tok_t       res_q;

  logic advance;
  tok_t result;

  // The byte moves into the lexer whenever the result stage is free or drains.
  assign advance   = byte_valid && (!res_valid || tok.ready);
  assign cmd.ready = !byte_valid || advance;

  clt_lexer u_lexer (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .step_char (byte_q),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (cmd.ready) begin
        byte_valid <= cmd.valid;
      end
      if (advance) begin
        res_valid <= 1'b1;
      end else if (tok.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      byte_q <= cmd.in_char;
    end
    if (advance) begin
      res_q <= result;
    end
  end

  assign tok.valid        = res_valid;
  assign tok.out_char     = res_q.out_char;
  assign tok.begins_arg   = res_q.begins_arg;
  assign tok.ends_command = res_q.ends_command;
  assign tok.arg_count    = res_q.arg_count;
  assign tok.overflow     = res_q.overflow;

endmodule

FILE: test/command_line_tokenizer_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for command_line_tokenizer_unit: directed and random byte streams.
// Depends on clt_pkg, the clt_cmd_if and clt_tok_if interfaces and the tokenizer RTL.

module command_line_tokenizer_unit_tb;
  import clt_pkg::*;

  // Lexer states of the scoreboard's own tokenizer copy.
  typedef enum logic [1:0] {
    LEX_SPACE  = 2'd0,
    LEX_TOKEN  = 2'd1,
    LEX_QUOTED = 2'd2,
    LEX_ESCAPE = 2'd3
  } lex_t;

  logic clk = 1'b0;
  logic rst;

  clt_cmd_if cmd();
  clt_tok_if tok();

  command_line_tokenizer_unit uut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .tok(tok)
  );

  // The clock runs at 100 MHz for the whole run.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the tokenizer state, advanced once per accepted byte.
  lex_t       lex_now;
  lex_t       lex_saved;
  logic [2:0] args_seen;
  logic       args_over;

  // Results still owed by the block, oldest first.
  tok_t expected_toks[$];
  tok_t want;

  // Percent chance of a gap before a byte and of a stall on the result side.
  int gap_pct;
  int stall_pct;
  int stall_left;

  int fails;
  int bytes_sent;
  int results_seen;
  int commands_done;

  // Mostly short pauses, now and then a long one; zero percent means none at all.
  function automatic int pick_pause(input int pct);
    if (pct == 0 || $urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  // A new argument bumps the count until it saturates; past that only the
  // overflow flag records it.
  function automatic void count_arg();
    if (args_seen < CountLimit) args_seen = args_seen + 3'd1;
    else args_over = 1'b1;
  endfunction

  // Works out the result for one byte and moves the shadow lexer on.
  function automatic tok_t tokenize_byte(input logic [7:0] c);
    tok_t r;
    lex_t nxt;
    r.out_char     = c;
    r.begins_arg   = BEGIN_NONE;
    r.ends_command = END_NONE;
    nxt            = lex_now;
    if (c == ChNul) begin
      // NUL always ends the line, even inside a string or after a backslash.
      r.ends_command = END_LINE;
    end else if (c == ChSemi && lex_now != LEX_QUOTED && lex_now != LEX_ESCAPE) begin
      r.ends_command = END_SEMI;
      r.out_char     = ChNul;
    end else if (lex_now == LEX_ESCAPE) begin
      // The escaped byte passes through and the lexer resumes where it was.
      nxt = lex_saved;
    end else if (lex_now == LEX_QUOTED) begin
      if (c == ChQuote) begin
        r.out_char = ChNul;
        nxt        = LEX_SPACE;
      end
    end else if (c == ChSpace || c == ChTab) begin
      r.out_char = ChNul;
      nxt        = LEX_SPACE;
    end else if (c == ChQuote) begin
      r.out_char   = ChNul;
      r.begins_arg = BEGIN_QUOTED;
      count_arg();
      nxt = LEX_QUOTED;
    end else if (c == ChBackslash) begin
      lex_saved = lex_now;
      nxt       = LEX_ESCAPE;
    end else begin
      if (lex_now == LEX_SPACE) begin
        r.begins_arg = BEGIN_BARE;
        count_arg();
      end
      nxt = LEX_TOKEN;
    end
    r.arg_count = args_seen;
    r.overflow  = args_over;
    // The result shows the final count; only then does the next command start clean.
    if (r.ends_command != END_NONE) begin
      lex_now   = LEX_SPACE;
      lex_saved = LEX_SPACE;
      args_seen = 3'd0;
      args_over = 1'b0;
    end else begin
      lex_now = nxt;
    end
    return r;
  endfunction

  // Offers one byte on cmd and records its expected result once the beat is taken.
  // When no gap is drawn, valid simply stays high and only the payload changes.
  task automatic send_byte(input logic [7:0] c);
    int gap;
    gap = pick_pause(gap_pct);
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid   <= 1'b1;
    cmd.in_char <= c;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    expected_toks.push_back(tokenize_byte(c));
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Holds the sender off until every owed result has come back, then lets the
  // pipeline of input register and result register settle.
  task automatic drain_results();
    cmd.valid <= 1'b0;
    do @(posedge clk); while (expected_toks.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Any byte at all that is neither blank, tab, quote, backslash, ';' nor NUL.
  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == ChSemi || c == ChQuote || c == ChBackslash || c == ChSpace || c == ChTab);
    return c;
  endfunction

  // One command with random content: bare words (sometimes with escapes), quoted
  // strings (sometimes left open), and a little raw noise, closed by ';' or NUL.
  task automatic send_random_command();
    int n;
    int i;
    int k;
    int len;
    int kind;
    n = $urandom_range(0, 9);
    for (i = 0; i < n; i++) begin
      if (i > 0 || $urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 2)) send_byte($urandom_range(1) ? ChSpace : ChTab);
      end
      kind = $urandom_range(9);
      if (kind <= 5) begin
        len = $urandom_range(1, 4);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(7) == 0) begin
            send_byte(ChBackslash);
            send_byte(8'($urandom_range(1, 255)));
          end else begin
            send_byte(plain_byte());
          end
        end
      end else if (kind <= 8) begin
        send_byte(ChQuote);
        len = $urandom_range(0, 4);
        for (k = 0; k < len; k++) begin
          send_byte($urandom_range(5) == 0 ? ChSemi :
                    ($urandom_range(5) == 0 ? ChBackslash : plain_byte()));
        end
        if ($urandom_range(9) != 0) send_byte(ChQuote);
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(3) == 0) send_byte(ChSpace);
    send_byte($urandom_range(1) ? ChSemi : ChNul);
  endtask

  // Result side: stalls of random length unless stall_pct is zero.
  always @(posedge clk) begin
    if (rst) begin
      tok.ready  <= 1'b0;
      stall_left = 0;
    end else begin
      if (stall_left == 0) stall_left = pick_pause(stall_pct);
      if (stall_left > 0) begin
        tok.ready  <= 1'b0;
        stall_left = stall_left - 1;
      end else begin
        tok.ready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      fails++;
    end
  endtask

  // Every result beat is matched against the oldest expectation, field by field.
  always @(posedge clk) begin
    if (!rst && tok.valid === 1'b1 && tok.ready === 1'b1) begin
      if (expected_toks.size() == 0) begin
        $error("out_char: expected no beat, got %0h", tok.out_char);
        fails++;
      end else begin
        want = expected_toks.pop_front();
        check_field("out_char", want.out_char, tok.out_char);
        check_field("begins_arg", want.begins_arg, tok.begins_arg);
        check_field("ends_command", want.ends_command, tok.ends_command);
        check_field("arg_count", want.arg_count, tok.arg_count);
        check_field("overflow", want.overflow, tok.overflow);
        results_seen++;
        if (want.ends_command != END_NONE) commands_done++;
      end
    end
  end

  // Blanks, tabs and runs of blanks between bare words, ended by NUL.
  task automatic test_word_split();
    gap_pct   = 30;
    stall_pct = 30;
    send_text("a\tb  c");
    send_byte(ChNul);
    drain_results();
  endtask

  // Empty quoted argument, ';' inside a string, backslash inside a string,
  // escaped ';' and escaped byte in blank state, and the extreme byte values.
  task automatic test_quotes_and_escapes();
    send_text("\"\";");
    send_text("\"x;\\\"");
    send_text("\\;");
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(ChSpace);
    send_text("\\a");
    send_byte(8'h7F);
    send_byte(ChBackslash);
    send_byte(ChNul);
    drain_results();
  endtask

  // Nine bare arguments in one command push the count past its limit.
  task automatic test_arg_limit();
    send_text("a b c d e f g h i;");
    drain_results();
  endtask

  // Commands with random content, both sides pausing at random.
  task automatic test_random_idle(input int target);
    gap_pct   = 40;
    stall_pct = 40;
    while (bytes_sent < target) send_random_command();
    drain_results();
  endtask

  // Full-rate stream with no pauses on either side.
  task automatic test_random_streaming(input int target);
    gap_pct   = 0;
    stall_pct = 0;
    while (bytes_sent < target) send_random_command();
    drain_results();
  endtask

  // Sender at full rate against a result side that stalls often.
  task automatic test_random_backpressure(input int target);
    gap_pct   = 0;
    stall_pct = 60;
    while (bytes_sent < target) send_random_command();
    drain_results();
  endtask

  initial begin
    rst         = 1'b1;
    cmd.valid   = 1'b0;
    cmd.in_char = 8'h00;
    tok.ready   = 1'b0;
    gap_pct     = 0;
    stall_pct   = 0;
    stall_left  = 0;
    fails         = 0;
    bytes_sent    = 0;
    results_seen  = 0;
    commands_done = 0;
    lex_now   = LEX_SPACE;
    lex_saved = LEX_SPACE;
    args_seen = 3'd0;
    args_over = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_word_split();
    test_quotes_and_escapes();
    test_arg_limit();
    test_random_idle(bytes_sent + 350);
    test_random_streaming(bytes_sent + 130);
    test_random_backpressure(bytes_sent + 100);

    if (expected_toks.size() != 0) begin
      $error("out_char: %0d results never arrived", expected_toks.size());
      fails++;
    end
    $display("Sent %0d bytes in %0d finished commands; %0d result beats compared.",
             bytes_sent, commands_done, results_seen);
    if (fails == 0) begin
      $display("command_line_tokenizer_unit_tb: clean");
    end else begin
      $display("command_line_tokenizer_unit_tb: errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, with every pause and stall at its longest.
  initial begin
    #3_000_000;
    $display("command_line_tokenizer_unit_tb: errors");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/clt_pkg.sv
design/clt_if.sv
design/clt_lexer.sv
design/command_line_tokenizer_unit.sv
test/command_line_tokenizer_unit_tb.sv
